>>> src/bdascii_pkg.sv
// Shared constants for the binary to decimal ASCII unit.
// No dependencies; imported by binary_to_decimal_ascii_unit and tb_top.
`default_nettype none

package bdascii_pkg;

    // Width of the binary input value
    localparam int unsigned VALUE_W = 32;
    // Width of one ASCII digit character
    localparam int unsigned CHAR_W = 6;
    // Output tdata width, padded to whole bytes
    localparam int unsigned M_DATA_W = 8;
    // Decimal digits a 32-bit value can need
    localparam int unsigned DIGIT_LIMIT = 10;
    // Default digit cap
    localparam int unsigned MAX_DIGITS_DEF = 10;
    // ASCII code of '0'
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
    // ASCII code of '9'
    localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;

endpackage : bdascii_pkg

`default_nettype wire

>>> src/binary_to_decimal_ascii_unit.sv
// Binary to decimal ASCII converter: bit-serial double dabble, then digit-serial emission.
// Depends on bdascii_pkg for widths and character constants.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[31:0] = value
//  m_      | out | m_tvalid/m_tready  | m_tdata[5:0] = digit_char, m_tlast = last_digit
//
// An item is shifted in one input bit per cycle through the add-3 digit chain,
// then the window is scanned from the top over MAX(1,MIN(MAX_DIGITS,10)) digit
// positions, skipping leading zeros.
// The output register holds one character; a stalled m_tready holds the scan.
// s_tready is high only between items; the last character may still wait in the
// output register while the next item is taken. Reset clears control state only.
`default_nettype none

module binary_to_decimal_ascii_unit
    import bdascii_pkg::*;
#(
    parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [VALUE_W-1:0]  s_tdata,   // [31:0] value
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                     m_tlast    // last_digit
);

    // Digits kept in the window; higher digits only show up as overflow
    localparam int unsigned NUM_DIG = (MAX_DIGITS > DIGIT_LIMIT) ? DIGIT_LIMIT :
                                      ((MAX_DIGITS < 1) ? 1 : MAX_DIGITS);
    localparam int unsigned BCD_W   = 4 * NUM_DIG;
    localparam int unsigned DIG_CW  = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;
    localparam int unsigned BIT_CW  = $clog2(VALUE_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_EMIT
    } state_t;

    state_t                state_reg, state_next;
    logic [VALUE_W-1:0]    shift_reg, shift_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BIT_CW-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [DIG_CW-1:0]     dig_cnt_reg, dig_cnt_next;
    logic                  seen_reg, seen_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [BCD_W-1:0]      bcd_adj;
    logic [3:0]            top_digit;
    logic                  emit_now;
    logic                  slot_free;
    logic                  load_out;

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign slot_free = !out_valid_reg || m_tready;
    // Emit once past the leading zeros, and always the final digit
    assign emit_now  = seen_reg || (top_digit != 4'd0) || (dig_cnt_reg == '0);
    assign load_out  = (state_reg == ST_EMIT) && emit_now && slot_free;

    // Next-state logic
    always_comb
    begin
        state_next     = state_reg;
        shift_next     = shift_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        // Drop the output item once taken
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    shift_next   = s_tdata;
                    bcd_next     = '0;
                    seen_next    = 1'b0;
                    bit_cnt_next = BIT_CW'(VALUE_W - 1);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // Shift one input bit into the digit chain; track overflow
                bcd_next   = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_W-1]};
                shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
                seen_next  = seen_reg | bcd_adj[BCD_W-1];
                if (bit_cnt_reg == '0)
                begin
                    dig_cnt_next = DIG_CW'(NUM_DIG - 1);
                    state_next   = ST_EMIT;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BIT_CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (!emit_now || slot_free)
                begin
                    if (emit_now)
                    begin
                        out_valid_next = 1'b1;
                        out_char_next  = ASCII_ZERO + CHAR_W'(top_digit);
                        out_last_next  = (dig_cnt_reg == '0);
                    end
                    // Advance to the next digit
                    bcd_next  = bcd_reg << 4;
                    seen_next = seen_reg | (top_digit != 4'd0);
                    if (dig_cnt_reg == '0)
                        state_next = ST_IDLE;
                    else
                        dig_cnt_next = dig_cnt_reg - DIG_CW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bcd_reg      <= bcd_next;
        bit_cnt_reg  <= bit_cnt_next;
        dig_cnt_reg  <= dig_cnt_next;
        seen_reg     <= seen_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - CHAR_W){1'b0}}, out_char_reg};
    assign m_tlast  = out_last_reg;

    // The final digit of a run ends the scan
    a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (dig_cnt_reg == '0)) |=> (state_reg == ST_IDLE))
        else $error("final digit loaded but scan did not end");

    // No output item is loaded while converting
    a_no_load_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) |=> !($rose(m_tvalid)))
        else $error("output loaded during conversion");

    // Every delivered character is a decimal digit
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_char_reg >= ASCII_ZERO) && (out_char_reg <= ASCII_NINE)))
        else $error("output character outside '0'..'9'");

endmodule : binary_to_decimal_ascii_unit

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for binary_to_decimal_ascii_unit: random values in, ASCII digits out.
// Depends on bdascii_pkg and the unit RTL; a digit scoreboard predicts every character.
module tb_top;
    import bdascii_pkg::*;

    localparam int unsigned DIGIT_CAP    = MAX_DIGITS_DEF;
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned DRAIN_CYCLES = 80;
    localparam int unsigned PHASE_ITEMS  = 52;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    // Predicts the digit run for each accepted value and checks emitted characters
    class digit_scoreboard;
        digit_t      expected_digits[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function int unsigned pending();
            return expected_digits.size();
        endfunction

        // Queue the characters of one accepted value, most significant first
        function void note_value(logic [VALUE_W-1:0] v);
            logic [3:0]         digs[20];
            logic [VALUE_W-1:0] rest;
            int unsigned        n;
            int unsigned        cap;
            digit_t             d;
            cap = (DIGIT_CAP > 20) ? 20 : DIGIT_CAP;
            if (v == '0)
            begin
                d.ch   = ASCII_ZERO;
                d.last = 1'b1;
                expected_digits.push_back(d);
                return;
            end
            rest = v;
            n    = 0;
            while (rest != '0 && n < cap)
            begin
                digs[n] = 4'(rest % 10);
                rest    = rest / 10;
                n++;
            end
            while (n > 0)
            begin
                n--;
                d.ch   = ASCII_ZERO + CHAR_W'(digs[n]);
                d.last = (n == 0);
                expected_digits.push_back(d);
            end
        endfunction

        // Compare one emitted character against the oldest expectation
        function void check_digit(logic [CHAR_W-1:0] ch, logic last);
            digit_t d;
            if (expected_digits.size() == 0)
            begin
                $display("%0t: unexpected digit: char %0d last %0b", $time, ch, last);
                errors++;
                return;
            end
            d = expected_digits.pop_front();
            if (ch !== d.ch)
            begin
                $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                         $time, d.ch, ch);
                errors++;
            end
            if (last !== d.last)
            begin
                $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                         $time, d.last, last);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic               m_tlast;

    digit_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_stall_pct;
    int unsigned     cycle_count;

    binary_to_decimal_ascii_unit #(
        .MAX_DIGITS (DIGIT_CAP)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Free-running clock
    always #6 clk = ~clk;

    // Randomize receiver backpressure at the falling edge
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted character
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_digit(m_tdata[CHAR_W-1:0], m_tlast);
        end
    end

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("binary_to_decimal_ascii_unit regression: fail");
        $finish;
    end

    // Offer one value after a random idle gap and hold it until taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
        begin
            gap++;
        end
        @(negedge clk);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sb.note_value(v);
    endtask

    // Mix of full-range words, values of a chosen digit count, bit patterns and small numbers
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] span;
        int unsigned ndig;
        int unsigned k;
        case ($urandom_range(3))
            0: return $urandom;
            1:
            begin
                ndig = $urandom_range(1, 10);
                lo   = 1;
                repeat (ndig - 1) lo = lo * 10;
                hi   = lo * 10 - 1;
                if (ndig == 1)
                    lo = 0;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                span = hi - lo + 1;
                return VALUE_W'(lo + ({$urandom, $urandom} % span));
            end
            2:
            begin
                k = $urandom_range(0, VALUE_W - 1);
                if ($urandom_range(1))
                    return VALUE_W'(64'd1 << k);
                else
                    return VALUE_W'((64'd1 << (k + 1)) - 1);
            end
            default: return VALUE_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Run one stretch of random values under the given idle and stall rates
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
        begin
            send_value(pick_value());
        end
    endtask

    initial
    begin
        logic [VALUE_W-1:0] directed[$];
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // Hold reset, release at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero, digit-count boundaries, trailing zeros, extremes, bit patterns
        directed = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                     32'd12345, 32'd65535, 32'd65536, 32'd99999999, 32'd100000000,
                     32'd999999999, 32'd1000000000, 32'd1234567890, 32'd2147483647,
                     32'd2147483648, 32'd4000000000, 32'd4294967290, 32'd4294967294,
                     32'd4294967295, 32'hAAAA_AAAA, 32'h5555_5555};
        foreach (directed[i])
        begin
            send_value(directed[i]);
        end

        // Random stretches: no idling, sender gaps, receiver stalls, both
        run_phase(0, 0);
        run_phase(63, 0);
        run_phase(0, 63);
        run_phase(22, 22);

        @(negedge clk);
        s_tvalid <= 1'b0;

        // Drain outstanding characters, then watch for strays
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("binary_to_decimal_ascii_unit regression: pass");
        end
        else
        begin
            $display("binary_to_decimal_ascii_unit regression: fail");
        end
        $finish;
    end

endmodule
